// ----- sv/eafd_pkg.sv -----
// Shared types and constants for the escaped API frame deframer.
`default_nettype none

package eafd_pkg;

	localparam int unsigned MAX_FRAME_DATA = 255;
	localparam int unsigned FIFO_DEPTH     = 2;
	localparam int unsigned FIFO_PTR_W     = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0] ESC_XOR   = 8'h20;
	localparam logic [7:0] SUM_GOOD  = 8'hFF;
	localparam logic [7:0] LEN_SAT   = 8'hFF;

	localparam logic [7:0] RST_START_MARKER  = 8'd126;
	localparam logic [7:0] RST_ESCAPE_MARKER = 8'd125;
	localparam logic [7:0] RST_CODE_TX       = 8'd139;
	localparam logic [7:0] RST_CODE_RX       = 8'd144;
	localparam logic [7:0] RST_CODE_IO       = 8'd146;
	localparam logic [7:0] RST_CODE_MODEM    = 8'd138;
	localparam logic [7:0] RST_CODE_CMD      = 8'd136;
	localparam logic [7:0] RST_CODE_REMOTE   = 8'd151;

	typedef enum logic [2:0] {
		REG_START_MARKER  = 3'd0,
		REG_ESCAPE_MARKER = 3'd1,
		REG_CODE_TX       = 3'd2,
		REG_CODE_RX       = 3'd3,
		REG_CODE_IO       = 3'd4,
		REG_CODE_MODEM    = 3'd5,
		REG_CODE_CMD      = 3'd6,
		REG_CODE_REMOTE   = 3'd7
	} reg_idx_t;

	typedef enum logic [2:0] {
		KIND_TX      = 3'd0,
		KIND_RX      = 3'd1,
		KIND_IO      = 3'd2,
		KIND_MODEM   = 3'd3,
		KIND_CMD     = 3'd4,
		KIND_REMOTE  = 3'd5,
		KIND_UNKNOWN = 3'd6
	} kind_t;

	typedef enum logic [1:0] {
		ST_GOOD     = 2'd0,
		ST_CSUM_ERR = 2'd1,
		ST_TOO_LONG = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_HUNT   = 2'd0,
		PH_LEN_HI = 2'd1,
		PH_LEN_LO = 2'd2,
		PH_DATA   = 2'd3
	} phase_t;

	// One classified word from the front: a start marker or an unescaped byte.
	typedef struct packed {
		logic       is_start;
		logic [7:0] data;
	} token_t;

	// Type codes, in register order (later entries win on a tie).
	typedef struct packed {
		logic [7:0] tx;
		logic [7:0] rx;
		logic [7:0] io;
		logic [7:0] modem;
		logic [7:0] cmd;
		logic [7:0] remote;
	} codes_t;

	typedef struct packed {
		logic       frame_end;
		logic [7:0] data_byte;
		logic [7:0] byte_index;
		kind_t      frame_kind;
		logic [7:0] frame_length;
		status_t    frame_status;
	} result_t;

endpackage

`default_nettype wire

// ----- sv/eafd_front.sv -----
// Front end: start/escape recognition and unescaping of raw bytes.
`default_nettype none

module eafd_front (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire  [7:0]           start_marker,
	input  wire  [7:0]           escape_marker,
	input  wire                  in_valid,
	output logic                 in_stall,
	input  wire  [7:0]           rx_byte,
	input  wire                  q_full,
	output logic                 q_push,
	output eafd_pkg::token_t     q_token
);

	logic esc_pending_q;
	logic accept;
	logic is_start;
	logic is_esc;

	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign is_start = (rx_byte == start_marker);
	assign is_esc   = !is_start && (rx_byte == escape_marker);

	// escape words produce no token
	assign q_push           = accept && !is_esc;
	assign q_token.is_start = is_start;
	assign q_token.data     = esc_pending_q ? (rx_byte ^ eafd_pkg::ESC_XOR) : rx_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_pending_q <= 1'b0;
		end else if (accept) begin
			esc_pending_q <= is_esc;
		end
	end

endmodule

`default_nettype wire

// ----- sv/eafd_fifo.sv -----
// Short token queue between front and back.
`default_nettype none

module eafd_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  wire eafd_pkg::token_t push_token,
	output logic                 full,
	input  wire                  pop,
	output logic                 not_empty,
	output eafd_pkg::token_t     head
);

	eafd_pkg::token_t                      entry_q [eafd_pkg::FIFO_DEPTH];
	logic [eafd_pkg::FIFO_PTR_W-1:0]       wr_ptr_q;
	logic [eafd_pkg::FIFO_PTR_W-1:0]       rd_ptr_q;
	logic [eafd_pkg::FIFO_CNT_W-1:0]       count_q;
	logic                                  do_push;
	logic                                  do_pop;

	assign full      = (count_q == eafd_pkg::FIFO_CNT_W'(eafd_pkg::FIFO_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_token;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == eafd_pkg::FIFO_PTR_W'(eafd_pkg::FIFO_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == eafd_pkg::FIFO_PTR_W'(eafd_pkg::FIFO_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/eafd_back.sv -----
// Back end: frame parser, checksum, classification and output register.
`default_nettype none

module eafd_back (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire eafd_pkg::codes_t codes,
	input  wire                  q_not_empty,
	input  wire eafd_pkg::token_t q_head,
	output logic                 q_pop,
	output logic                 out_valid,
	input  wire                  out_stall,
	output eafd_pkg::result_t    result
);

	eafd_pkg::phase_t  phase_q;
	eafd_pkg::phase_t  phase_d;
	logic              len_hi_nz_q;
	logic [7:0]        len_q;
	logic [7:0]        idx_q;
	logic [7:0]        sum_q;
	logic [7:0]        type_q;
	logic              out_valid_q;
	eafd_pkg::result_t res_q;

	logic              out_free;
	logic              too_long;
	logic              last_byte;
	logic [7:0]        sum_next;
	eafd_pkg::kind_t   kind;
	logic              res_valid;
	eafd_pkg::result_t res_d;

	assign out_free  = !out_valid_q || !out_stall;
	assign q_pop     = q_not_empty && out_free;
	assign too_long  = len_hi_nz_q || (q_head.data > 8'(eafd_pkg::MAX_FRAME_DATA));
	assign last_byte = (idx_q == len_q);
	assign sum_next  = sum_q + q_head.data;

	// later code registers win
	always_comb begin
		kind = eafd_pkg::KIND_UNKNOWN;
		if (len_q != '0) begin
			if (type_q == codes.tx)     kind = eafd_pkg::KIND_TX;
			if (type_q == codes.rx)     kind = eafd_pkg::KIND_RX;
			if (type_q == codes.io)     kind = eafd_pkg::KIND_IO;
			if (type_q == codes.modem)  kind = eafd_pkg::KIND_MODEM;
			if (type_q == codes.cmd)    kind = eafd_pkg::KIND_CMD;
			if (type_q == codes.remote) kind = eafd_pkg::KIND_REMOTE;
		end
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		if (q_pop) begin
			if (q_head.is_start) begin
				phase_d = eafd_pkg::PH_LEN_HI;
			end else begin
				unique case (phase_q)
					eafd_pkg::PH_HUNT:   phase_d = eafd_pkg::PH_HUNT;
					eafd_pkg::PH_LEN_HI: phase_d = eafd_pkg::PH_LEN_LO;
					eafd_pkg::PH_LEN_LO: phase_d = too_long ? eafd_pkg::PH_HUNT :
						eafd_pkg::PH_DATA;
					eafd_pkg::PH_DATA:   phase_d = last_byte ? eafd_pkg::PH_HUNT :
						eafd_pkg::PH_DATA;
					default:             phase_d = eafd_pkg::PH_HUNT;
				endcase
			end
		end
	end

	// result generation
	always_comb begin
		res_valid          = 1'b0;
		res_d.frame_end    = 1'b0;
		res_d.data_byte    = q_head.data;
		res_d.byte_index   = '0;
		res_d.frame_kind   = eafd_pkg::KIND_TX;
		res_d.frame_length = '0;
		res_d.frame_status = eafd_pkg::ST_GOOD;
		if (q_pop && !q_head.is_start) begin
			unique case (phase_q)
				eafd_pkg::PH_LEN_LO: begin
					if (too_long) begin
						res_valid          = 1'b1;
						res_d.frame_end    = 1'b1;
						res_d.frame_kind   = eafd_pkg::KIND_UNKNOWN;
						res_d.frame_length = eafd_pkg::LEN_SAT;
						res_d.frame_status = eafd_pkg::ST_TOO_LONG;
					end
				end
				eafd_pkg::PH_DATA: begin
					res_valid = 1'b1;
					if (last_byte) begin
						res_d.frame_end    = 1'b1;
						res_d.frame_kind   = kind;
						res_d.frame_length = len_q;
						res_d.frame_status = (sum_next == eafd_pkg::SUM_GOOD) ?
							eafd_pkg::ST_GOOD : eafd_pkg::ST_CSUM_ERR;
					end else begin
						res_d.byte_index = idx_q;
					end
				end
				default: res_valid = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= eafd_pkg::PH_HUNT;
			out_valid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (out_free) begin
				out_valid_q <= res_valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res_d;
		end
		if (q_pop) begin
			if (q_head.is_start) begin
				idx_q  <= '0;
				sum_q  <= '0;
				type_q <= '0;
			end else begin
				unique case (phase_q)
					eafd_pkg::PH_LEN_HI: len_hi_nz_q <= (q_head.data != '0);
					eafd_pkg::PH_LEN_LO: len_q <= q_head.data;
					eafd_pkg::PH_DATA: begin
						sum_q <= sum_next;
						idx_q <= idx_q + 1'b1;
						if (idx_q == '0) begin
							type_q <= q_head.data;
						end
					end
					default: len_q <= len_q;
				endcase
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result    = res_q;

endmodule

`default_nettype wire

// ----- sv/escaped_api_frame_deframer.sv -----
// Top level of the escaped API frame deframer: config registers, front, queue, back.
`default_nettype none

//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------
//  config  | cfg_we              | cfg_index[2:0], cfg_data[7:0]
//  input   | in_valid / in_stall | rx_byte[7:0]
//  output  | out_valid/out_stall | frame_end, data_byte, byte_index,
//          |                     | frame_kind, frame_length, frame_status
//
// One input word per cycle sustained while the token queue is not full; a word
// with a result passes the queue to the output register behind tokens queued ahead.
// The front stalls only when the two-entry token queue is full; the back end
// drains the queue whenever the output register is empty or being taken.
// Reset clears control state and loads the default marker and type codes.

module escaped_api_frame_deframer (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          cfg_we,
	input  wire  [2:0]   cfg_index,
	input  wire  [7:0]   cfg_data,
	input  wire          in_valid,
	output logic         in_stall,
	input  wire  [7:0]   rx_byte,
	output logic         out_valid,
	input  wire          out_stall,
	output logic         frame_end,
	output logic [7:0]   data_byte,
	output logic [7:0]   byte_index,
	output logic [2:0]   frame_kind,
	output logic [7:0]   frame_length,
	output logic [1:0]   frame_status
);

	logic [7:0]        start_marker_q;
	logic [7:0]        escape_marker_q;
	eafd_pkg::codes_t  codes_q;

	logic              q_push;
	logic              q_full;
	logic              q_pop;
	logic              q_not_empty;
	eafd_pkg::token_t  q_in;
	eafd_pkg::token_t  q_head;
	eafd_pkg::result_t result;

	// config register file; the user must write it only while idle, the block does not enforce it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_marker_q  <= eafd_pkg::RST_START_MARKER;
			escape_marker_q <= eafd_pkg::RST_ESCAPE_MARKER;
			codes_q.tx      <= eafd_pkg::RST_CODE_TX;
			codes_q.rx      <= eafd_pkg::RST_CODE_RX;
			codes_q.io      <= eafd_pkg::RST_CODE_IO;
			codes_q.modem   <= eafd_pkg::RST_CODE_MODEM;
			codes_q.cmd     <= eafd_pkg::RST_CODE_CMD;
			codes_q.remote  <= eafd_pkg::RST_CODE_REMOTE;
		end else if (cfg_we) begin
			unique case (eafd_pkg::reg_idx_t'(cfg_index))
				eafd_pkg::REG_START_MARKER:  start_marker_q  <= cfg_data;
				eafd_pkg::REG_ESCAPE_MARKER: escape_marker_q <= cfg_data;
				eafd_pkg::REG_CODE_TX:       codes_q.tx      <= cfg_data;
				eafd_pkg::REG_CODE_RX:       codes_q.rx      <= cfg_data;
				eafd_pkg::REG_CODE_IO:       codes_q.io      <= cfg_data;
				eafd_pkg::REG_CODE_MODEM:    codes_q.modem   <= cfg_data;
				eafd_pkg::REG_CODE_CMD:      codes_q.cmd     <= cfg_data;
				eafd_pkg::REG_CODE_REMOTE:   codes_q.remote  <= cfg_data;
				default:                     codes_q         <= codes_q;
			endcase
		end
	end

	// front: drops escape words, unescapes, tags start markers
	eafd_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.start_marker  (start_marker_q),
		.escape_marker (escape_marker_q),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.rx_byte       (rx_byte),
		.q_full        (q_full),
		.q_push        (q_push),
		.q_token       (q_in)
	);

	eafd_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_token (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.not_empty  (q_not_empty),
		.head       (q_head)
	);

	// back: length capture, checksum, classification, output register
	eafd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.codes       (codes_q),
		.q_not_empty (q_not_empty),
		.q_head      (q_head),
		.q_pop       (q_pop),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.result      (result)
	);

	assign frame_end    = result.frame_end;
	assign data_byte    = result.data_byte;
	assign byte_index   = result.byte_index;
	assign frame_kind   = result.frame_kind;
	assign frame_length = result.frame_length;
	assign frame_status = result.frame_status;

endmodule

`default_nettype wire

// ----- tb/deframer_scoreboard.sv -----
// Scoreboard package for the deframer: byte-level frame predictor and result checker.
`timescale 1ns / 1ps

package deframer_scoreboard_pkg;
	import eafd_pkg::*;

	class deframer_scoreboard;
		logic [7:0]  start_mk;
		logic [7:0]  esc_mk;
		logic [7:0]  codes [6];
		bit          in_frame;
		bit          esc_pend;
		int unsigned pos;
		logic [15:0] len_val;
		logic [7:0]  sum;
		logic [7:0]  type_b;
		result_t     frame_results_q [$];
		int unsigned errors;

		function new();
			start_mk = RST_START_MARKER;
			esc_mk   = RST_ESCAPE_MARKER;
			codes[0] = RST_CODE_TX;
			codes[1] = RST_CODE_RX;
			codes[2] = RST_CODE_IO;
			codes[3] = RST_CODE_MODEM;
			codes[4] = RST_CODE_CMD;
			codes[5] = RST_CODE_REMOTE;
			in_frame = 1'b0;
			esc_pend = 1'b0;
			pos      = 0;
			len_val  = '0;
			sum      = '0;
			type_b   = '0;
			errors   = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [7:0] v);
			case (idx)
				REG_START_MARKER: begin
					start_mk = v;
				end
				REG_ESCAPE_MARKER: begin
					esc_mk = v;
				end
				default: begin
					codes[int'(idx) - int'(REG_CODE_TX)] = v;
				end
			endcase
		endfunction

		function int unsigned outstanding();
			return frame_results_q.size();
		endfunction

		// later code registers win on a tie; empty frames have no type byte
		function kind_t kind_of();
			kind_t k;
			k = KIND_UNKNOWN;
			if (len_val == 0) begin
				return KIND_UNKNOWN;
			end
			for (int i = 0; i < 6; i++) begin
				if (type_b == codes[i]) begin
					k = kind_t'(i);
				end
			end
			return k;
		endfunction

		function void queue_result(logic fe, logic [7:0] db, logic [7:0] idx, kind_t k,
				logic [7:0] len, status_t st);
			result_t r;
			r.frame_end    = fe;
			r.data_byte    = db;
			r.byte_index   = idx;
			r.frame_kind   = k;
			r.frame_length = len;
			r.frame_status = st;
			frame_results_q.push_back(r);
		endfunction

		function void note_byte(logic [7:0] raw);
			logic [7:0] b;
			status_t    st;
			if (raw == start_mk) begin
				in_frame = 1'b1;
				esc_pend = 1'b0;
				pos      = 1;
				len_val  = '0;
				sum      = '0;
				type_b   = '0;
				return;
			end
			if (!in_frame) begin
				return;
			end
			if (raw == esc_mk) begin
				esc_pend = 1'b1;
				return;
			end
			b = esc_pend ? (raw ^ ESC_XOR) : raw;
			esc_pend = 1'b0;
			if (pos == 1) begin
				len_val = {b, 8'h00};
				pos = 2;
				return;
			end
			if (pos == 2) begin
				len_val[7:0] = b;
				if (len_val > MAX_FRAME_DATA) begin
					in_frame = 1'b0;
					queue_result(1'b1, b, 8'd0, KIND_UNKNOWN, LEN_SAT, ST_TOO_LONG);
				end else begin
					pos = 3;
				end
				return;
			end
			sum = sum + b;
			if (pos - 3 == len_val) begin
				st = (sum == SUM_GOOD) ? ST_GOOD : ST_CSUM_ERR;
				in_frame = 1'b0;
				queue_result(1'b1, b, 8'd0, kind_of(), len_val[7:0], st);
				return;
			end
			if (pos == 3) begin
				type_b = b;
			end
			queue_result(1'b0, b, 8'(pos - 3), KIND_TX, 8'd0, ST_GOOD);
			pos = pos + 1;
		endfunction

		function void report_field(string field, logic [7:0] want_v, logic [7:0] got_v);
			errors++;
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want_v, got_v);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (frame_results_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none, got end=%0d byte=%0d idx=%0d",
					$time, got.frame_end, got.data_byte, got.byte_index);
				return;
			end
			want = frame_results_q.pop_front();
			if (got.frame_end !== want.frame_end) begin
				report_field("frame_end", want.frame_end, got.frame_end);
			end
			if (got.data_byte !== want.data_byte) begin
				report_field("data_byte", want.data_byte, got.data_byte);
			end
			if (got.byte_index !== want.byte_index) begin
				report_field("byte_index", want.byte_index, got.byte_index);
			end
			if (got.frame_kind !== want.frame_kind) begin
				report_field("frame_kind", want.frame_kind, got.frame_kind);
			end
			if (got.frame_length !== want.frame_length) begin
				report_field("frame_length", want.frame_length, got.frame_length);
			end
			if (got.frame_status !== want.frame_status) begin
				report_field("frame_status", want.frame_status, got.frame_status);
			end
		endfunction
	endclass

endpackage

// ----- tb/testbench.sv -----
// Testbench for the escaped API frame deframer: framed byte traffic checked by a scoreboard.
`timescale 1ns / 1ps

module testbench;
	import eafd_pkg::*;
	import deframer_scoreboard_pkg::*;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       cfg_we    = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [7:0] cfg_data  = '0;
	logic       in_valid  = 1'b0;
	logic       in_stall;
	logic [7:0] rx_byte   = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic       frame_end;
	logic [7:0] data_byte;
	logic [7:0] byte_index;
	logic [2:0] frame_kind;
	logic [7:0] frame_length;
	logic [1:0] frame_status;

	deframer_scoreboard sb = new();

	// idle rates per phase, in percent
	int unsigned send_idle_pct  = 0;
	int unsigned recv_stall_pct = 0;
	// long receiver hold-off: sender bumps tickets, receiver counts the cycles
	int unsigned hold_tickets = 0;
	int unsigned hold_served  = 0;
	int unsigned hold_left    = 0;
	int unsigned bytes_sent   = 0;

	escaped_api_frame_deframer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.frame_end    (frame_end),
		.data_byte    (data_byte),
		.byte_index   (byte_index),
		.frame_kind   (frame_kind),
		.frame_length (frame_length),
		.frame_status (frame_status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// receiver: random stall, or a long hold when the sender asks for one
	always @(negedge clk) begin
		if (hold_tickets != hold_served) begin
			hold_served = hold_tickets;
			hold_left   = 300;
		end
		if (hold_left != 0) begin
			hold_left = hold_left - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// every word taken at the edge goes to the scoreboard
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			sb.check_result(result_t'{frame_end, data_byte, byte_index, kind_t'(frame_kind),
				frame_length, status_t'(frame_status)});
		end
	end

	// Offer one byte; called and returning at a falling edge. Valid stays up
	// until the next call or a drain lowers it.
	task automatic send_byte(input logic [7:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= b;
		do begin
			@(posedge clk);
		end while (in_stall);
		sb.note_byte(b);
		bytes_sent++;
		@(negedge clk);
	endtask

	// Byte-stuff a frame byte. Markers must be escaped; other bytes now and then
	// too, as long as the flipped value is not a marker. Sometimes the escape is
	// doubled, which the deframer treats as a single one.
	task automatic send_coded(input logic [7:0] b);
		logic [7:0] alt;
		alt = b ^ ESC_XOR;
		if (b == sb.start_mk || b == sb.esc_mk
				|| (alt != sb.start_mk && alt != sb.esc_mk && $urandom_range(99) < 4)) begin
			if ($urandom_range(99) < 10) begin
				send_byte(sb.esc_mk);
			end
			send_byte(sb.esc_mk);
			send_byte(alt);
		end else begin
			send_byte(b);
		end
	endtask

	// Start, length, type and data, checksum. A truncated frame stops somewhere
	// in the body without a checksum; an oversize length ends at the length.
	task automatic send_frame(input logic [15:0] len, input logic [7:0] type_code,
			input bit corrupt, input bit truncate);
		logic [7:0]  acc;
		logic [7:0]  b;
		int unsigned cut;
		int unsigned i;
		cut = truncate ? $urandom_range(0, len) : len + 1;
		send_byte(sb.start_mk);
		send_coded(len[15:8]);
		send_coded(len[7:0]);
		if (len > MAX_FRAME_DATA) begin
			return;
		end
		acc = '0;
		for (i = 0; i < len; i++) begin
			if (i == cut) begin
				return;
			end
			b = (i == 0) ? type_code : 8'($urandom_range(255));
			acc = acc + b;
			send_coded(b);
		end
		if (truncate) begin
			return;
		end
		b = SUM_GOOD - acc;
		if (corrupt) begin
			b = b ^ 8'($urandom_range(1, 255));
		end
		send_coded(b);
	endtask

	// Sender stops and waits for every expected word, then lets the pipe empty.
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.outstanding() != 0) begin
			@(negedge clk);
		end
		repeat (8) @(negedge clk);
	endtask

	// write_reg leaves the enable up; set_config drops it after the last write
	task automatic write_reg(input reg_idx_t idx, input logic [7:0] v);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		sb.set_reg(idx, v);
		@(negedge clk);
	endtask

	task automatic set_config(input logic [7:0] start_v, esc_v, tx_v, rx_v, io_v, modem_v,
			cmd_v, remote_v);
		write_reg(REG_START_MARKER, start_v);
		write_reg(REG_ESCAPE_MARKER, esc_v);
		write_reg(REG_CODE_TX, tx_v);
		write_reg(REG_CODE_RX, rx_v);
		write_reg(REG_CODE_IO, io_v);
		write_reg(REG_CODE_MODEM, modem_v);
		write_reg(REG_CODE_CMD, cmd_v);
		write_reg(REG_CODE_REMOTE, remote_v);
		cfg_we <= 1'b0;
	endtask

	task automatic apply_setting(input int unsigned sel);
		logic [7:0] c;
		logic [7:0] d;
		c = 8'($urandom_range(255));
		d = c ^ 8'($urandom_range(1, 255));
		case (sel)
			0: begin
				set_config(RST_START_MARKER, RST_ESCAPE_MARKER, RST_CODE_TX, RST_CODE_RX,
					RST_CODE_IO, RST_CODE_MODEM, RST_CODE_CMD, RST_CODE_REMOTE);
			end
			1: begin
				set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h01, 8'hFE, 8'h80, 8'h7F);
			end
			2: begin
				// 0x00 escapes to 0x20 and 0xFF to 0xDF, so two type codes collide with stuffing
				set_config(8'hFF, 8'h00, 8'hFF, 8'h00, 8'h20, 8'hDF, 8'h5A, 8'hA5);
			end
			3: begin
				// tied codes: c resolves to remote, d to cmd
				set_config(8'($urandom_range(255)), 8'($urandom_range(255)), c, c, c, d, d, c);
			end
			default: begin
				set_config(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(255)), 8'($urandom_range(255)));
			end
		endcase
	endtask

	function automatic logic [15:0] pick_length();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 60) begin
			return 16'($urandom_range(0, 8));
		end else if (r < 85) begin
			return 16'($urandom_range(9, 40));
		end else if (r < 92) begin
			return 16'($urandom_range(41, 254));
		end else if (r < 93) begin
			return 16'd255;
		end
		return 16'($urandom_range(256, 65535));
	endfunction

	function automatic logic [7:0] pick_type();
		if ($urandom_range(99) < 80) begin
			return sb.codes[$urandom_range(5)];
		end
		return 8'($urandom_range(255));
	endfunction

	// Directed opening with reset markers (start 7E, escape 7D, tx code 8B):
	// noise while hunting, empty frame, length of 256, double escape then a
	// restart inside a frame, an escaped data byte, and a bad checksum.
	logic [7:0] opening [26] = '{
		8'h00, 8'hFF,
		8'h7E, 8'h00, 8'h00, 8'hFF,
		8'h7E, 8'h01, 8'h00,
		8'h7E, 8'h00, 8'h7D, 8'h7D, 8'h22,
		8'h7E, 8'h00, 8'h02, 8'h8B, 8'h7D, 8'h5E, 8'hF6,
		8'h7E, 8'h00, 8'h01, 8'hFF, 8'h01
	};

	initial begin
		int unsigned ph;
		int unsigned r;
		int unsigned phase_end;
		int unsigned mid;
		bit          paused;
		int unsigned n;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (opening[i]) begin
			send_byte(opening[i]);
		end
		drain();

		for (ph = 0; ph < 8; ph++) begin
			apply_setting(ph % 5);
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 62;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 62;
				end
				default: begin
					send_idle_pct  = 8;
					recv_stall_pct = 8;
				end
			endcase
			phase_end = bytes_sent + 100;
			mid       = bytes_sent + 50;
			paused    = 1'b0;
			// receiver holds off while a long frame is pushed, so the input backs up
			if (ph == 2 || ph == 5) begin
				hold_tickets++;
				send_frame(16'd40, pick_type(), 1'b0, 1'b0);
			end
			while (bytes_sent < phase_end) begin
				if (!paused && bytes_sent >= mid) begin
					drain();
					paused = 1'b1;
				end
				r = $urandom_range(99);
				if (r < 80) begin
					send_frame(pick_length(), pick_type(), $urandom_range(99) < 15, 1'b0);
				end else if (r < 90) begin
					send_frame(pick_length(), pick_type(), 1'b0, 1'b1);
				end else begin
					// line noise, which may itself hold a start marker
					n = $urandom_range(1, 4);
					repeat (n) send_byte(8'($urandom_range(255)));
				end
			end
			drain();
		end

		if (sb.errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
